// ===== hdl/bcdu_pkg.sv =====
// bcdu_pkg: shared types, operation codes and constants of the decimal-adjust unit
`default_nettype none
package bcdu_pkg;

	// operation codes carried in the mode field
	localparam logic [2:0] MODE_AAA = 3'd0;
	localparam logic [2:0] MODE_AAS = 3'd1;
	localparam logic [2:0] MODE_DAA = 3'd2;
	localparam logic [2:0] MODE_DAS = 3'd3;
	localparam logic [2:0] MODE_AAM = 3'd4;
	localparam logic [2:0] MODE_AAD = 3'd5;

	// one cell per bit of the 8-bit divide and multiply
	localparam int unsigned STEPS = 8;

	localparam logic [7:0] LOW_NIBBLE = 8'h0F;
	localparam logic [3:0] DIGIT_MAX  = 4'd9;
	localparam logic [7:0] BYTE_MAX   = 8'h99;
	localparam logic [7:0] ADJ_LOW    = 8'h06;
	localparam logic [7:0] ADJ_HIGH   = 8'h60;

	// what a cell does to the beat it holds
	typedef enum logic [1:0] {
		KIND_PASS = 2'd0,
		KIND_DIV  = 2'd1,
		KIND_MUL  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] al_in;
		logic [7:0] ah_in;
		logic       af_in;
		logic       cf_in;
		logic       sf_in;
		logic       zf_in;
		logic       pf_in;
		logic [7:0] imm_byte;
	} cmd_beat_t;

	typedef struct packed {
		logic [7:0] al_out;
		logic [7:0] ah_out;
		logic       af_out;
		logic       cf_out;
		logic       sf_out;
		logic       zf_out;
		logic       pf_out;
		logic       divide_error;
	} res_beat_t;

	// beat as it walks down the cell chain
	typedef struct packed {
		logic       valid;
		kind_t      kind;
		logic [7:0] rem;   // partial remainder or product accumulator
		logic [7:0] work;  // dividend shifting into quotient, or multiplier
		logic [7:0] opnd;  // divisor or multiplicand
		logic [7:0] al;
		logic [7:0] ah;
		logic       af;
		logic       cf;
		logic       sf;
		logic       zf;
		logic       pf;
		logic       derr;
	} cell_beat_t;

endpackage
`default_nettype wire

// ===== hdl/bcd_adjust_unit.sv =====
// bcd_adjust_unit: top level of the 8086 decimal-adjust unit
`default_nettype none
// usage
//  - command channel: cmd is taken at a rising edge with start high and busy low;
//    busy stays low, so a new command beat can go in every cycle
//  - result channel: done is high for one cycle with result valid; the receiver
//    cannot stall, so nothing is held back
//  - aaa, aas, daa and das are settled at entry and simply ride the chain
//  - aam runs a restoring divide, one quotient bit per cell, over eight cells
//  - aad runs a shift-add multiply, one multiplier bit per cell, with al added
//    in the output stage
//  - the first cell loads at the edge that takes the command; the beat then
//    passes the seven further cells and the output register, and done rises as
//    the output register loads; throughput one beat per cycle, set by the
//    eight-cell chain being fully pipelined
//  - aam with a zero immediate flags divide_error and returns the inputs as is
//  - reset clears all valid bits in the chain and the done strobe; beats in
//    flight are dropped
module bcd_adjust_unit import bcdu_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	output logic           busy,
	input  wire cmd_beat_t cmd,
	output logic           done,
	output res_beat_t      result
);

	cell_beat_t chain [0:STEPS];
	cell_beat_t entry;
	logic       low_adj;
	logic       high_adj;
	logic [7:0] al_dec;
	logic [7:0] al_new;
	res_beat_t  res_nxt;
	res_beat_t  result_q;
	logic       done_q;

	function automatic logic even_parity(input logic [7:0] v);
		even_parity = ~(^v);
	endfunction

	// never stalls: the chain moves every cycle
	assign busy = 1'b0;

	// entry decode and the short decimal adjusts
	always_comb begin
		low_adj  = ((cmd.al_in & LOW_NIBBLE) > {4'h0, DIGIT_MAX}) || cmd.af_in;
		high_adj = (cmd.al_in > BYTE_MAX) || cmd.cf_in;
		al_dec   = cmd.al_in;

		entry       = '0;
		entry.valid = start && !busy;
		entry.kind  = KIND_PASS;
		entry.al    = cmd.al_in;
		entry.ah    = cmd.ah_in;
		entry.af    = cmd.af_in;
		entry.cf    = cmd.cf_in;
		entry.sf    = cmd.sf_in;
		entry.zf    = cmd.zf_in;
		entry.pf    = cmd.pf_in;
		entry.derr  = 1'b0;
		entry.rem   = 8'h00;
		entry.work  = cmd.al_in;
		entry.opnd  = cmd.imm_byte;

		unique case (cmd.mode)
			MODE_AAA, MODE_AAS: begin
				if (low_adj) begin
					entry.al = (cmd.mode == MODE_AAA) ? (cmd.al_in + ADJ_LOW)
						: (cmd.al_in - ADJ_LOW);
					entry.ah = (cmd.mode == MODE_AAA) ? (cmd.ah_in + 8'd1)
						: (cmd.ah_in - 8'd1);
				end
				entry.al = entry.al & LOW_NIBBLE;
				entry.af = low_adj;
				entry.cf = low_adj;
			end
			MODE_DAA, MODE_DAS: begin
				// two-stage correction, high stage decided on the old al
				if (low_adj) begin
					al_dec = (cmd.mode == MODE_DAA) ? (cmd.al_in + ADJ_LOW)
						: (cmd.al_in - ADJ_LOW);
				end
				if (high_adj) begin
					al_dec = (cmd.mode == MODE_DAA) ? (al_dec + ADJ_HIGH)
						: (al_dec - ADJ_HIGH);
				end
				entry.al = al_dec;
				entry.af = low_adj;
				entry.cf = high_adj;
			end
			MODE_AAM: begin
				if (cmd.imm_byte == 8'h00) begin
					entry.derr = 1'b1;
				end else begin
					entry.kind = KIND_DIV;
				end
			end
			MODE_AAD: begin
				entry.kind = KIND_MUL;
				entry.work = cmd.ah_in;
			end
			default: begin
				// unused codes pass everything through
				entry.kind = KIND_PASS;
			end
		endcase
	end

	assign chain[0] = entry;

	// eight identical cells, one quotient or multiplier bit each
	for (genvar i = 0; i < STEPS; i++) begin : g_cell
		bcdu_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.d      (chain[i]),
			.q      (chain[i+1])
		);
	end

	// output stage: pick up remainder, quotient or product and refresh flags
	always_comb begin
		al_new               = chain[STEPS].al;
		res_nxt.al_out       = chain[STEPS].al;
		res_nxt.ah_out       = chain[STEPS].ah;
		res_nxt.af_out       = chain[STEPS].af;
		res_nxt.cf_out       = chain[STEPS].cf;
		res_nxt.sf_out       = chain[STEPS].sf;
		res_nxt.zf_out       = chain[STEPS].zf;
		res_nxt.pf_out       = chain[STEPS].pf;
		res_nxt.divide_error = chain[STEPS].derr;
		unique case (chain[STEPS].kind)
			KIND_DIV: begin
				al_new         = chain[STEPS].rem;
				res_nxt.ah_out = chain[STEPS].work;
			end
			KIND_MUL: begin
				al_new         = chain[STEPS].al + chain[STEPS].rem;
				res_nxt.ah_out = 8'h00;
			end
			default: begin
				al_new = chain[STEPS].al;
			end
		endcase
		res_nxt.al_out = al_new;
		if (chain[STEPS].kind != KIND_PASS) begin
			res_nxt.sf_out = al_new[7];
			res_nxt.zf_out = (al_new == 8'h00);
			res_nxt.pf_out = even_parity(al_new);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= chain[STEPS].valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_nxt;
	end

	assign done   = done_q;
	assign result = result_q;

	// a result beat always traces back to a command taken earlier
	a_done_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, STEPS + 1))
		else $error("result beat without a command");

	// divide_error only for aam with zero immediate
	a_derr_src: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.divide_error) |->
		($past(cmd.mode, STEPS + 1) == MODE_AAM && $past(cmd.imm_byte, STEPS + 1) == 8'h00))
		else $error("divide_error without zero aam immediate");

	// aam remainder stays below the base
	a_aam_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(cmd.mode, STEPS + 1) == MODE_AAM && !result.divide_error) |->
		(result.al_out < $past(cmd.imm_byte, STEPS + 1)))
		else $error("aam remainder not below base");

	// aad clears ah
	a_aad_ah: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(cmd.mode, STEPS + 1) == MODE_AAD) |-> (result.ah_out == 8'h00))
		else $error("aad left ah nonzero");

endmodule
`default_nettype wire

// ===== hdl/bcdu_cell.sv =====
// bcdu_cell: one step of restoring divide or shift-add multiply, or a plain pass, registered
`default_nettype none
module bcdu_cell import bcdu_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cell_beat_t d,
	output cell_beat_t      q
);

	cell_beat_t nxt;
	logic [8:0] trial;
	logic [8:0] diff;
	logic       fits;
	cell_beat_t beat_q;
	logic       valid_q;

	always_comb begin
		nxt   = d;
		trial = {d.rem, d.work[7]};
		diff  = trial - {1'b0, d.opnd};
		fits  = (trial >= {1'b0, d.opnd});
		unique case (d.kind)
			KIND_DIV: begin
				nxt.rem  = fits ? diff[7:0] : trial[7:0];
				nxt.work = {d.work[6:0], fits};
			end
			KIND_MUL: begin
				nxt.rem  = {d.rem[6:0], 1'b0} + (d.work[7] ? d.opnd : 8'h00);
				nxt.work = {d.work[6:0], 1'b0};
			end
			default: begin
				nxt = d;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		beat_q <= nxt;
	end

	always_comb begin
		q       = beat_q;
		q.valid = valid_q;
	end

endmodule
`default_nettype wire

// ===== bench/tb_bcd_adjust_unit.sv =====
// tb_bcd_adjust_unit: self-checking bench for the decimal-adjust unit, table plus random beats
`default_nettype none
module tb_bcd_adjust_unit import bcdu_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	// the two mode codes the unit treats as no-ops
	localparam logic [2:0] MODE_SPARE_6 = 3'd6;
	localparam logic [2:0] MODE_SPARE_7 = 3'd7;

	localparam int unsigned RANDOM_BEATS  = 2000;
	localparam int unsigned DRAIN_EVERY   = 400;  // sender waits for an empty pipe this often
	localparam int unsigned TAIL_CYCLES   = 12;   // covers the unit's latency plus margin
	localparam int unsigned REPORT_LIMIT  = 10;

	logic      clk    = 1'b0;
	logic      arst_n = 1'b0;
	logic      start  = 1'b0;
	cmd_beat_t cmd    = '0;
	logic      busy;
	logic      done;
	res_beat_t result;

	// one row of the directed table; typed rows carry their answer, the rest ask the model
	typedef struct {
		cmd_beat_t c;
		bit        typed;
		res_beat_t want;
	} directed_row_t;

	directed_row_t directed_rows[$];
	res_beat_t     expected_adjusts[$];  // register and flag values still owed by the unit
	int unsigned   mismatch_count = 0;

	bcd_adjust_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// flags are packed af, cf, sf, zf, pf from msb to lsb
	function automatic cmd_beat_t cmd_of(logic [2:0] mode, logic [7:0] al, logic [7:0] ah,
			logic [4:0] f, logic [7:0] imm);
		cmd_beat_t c;
		c.mode     = mode;
		c.al_in    = al;
		c.ah_in    = ah;
		{c.af_in, c.cf_in, c.sf_in, c.zf_in, c.pf_in} = f;
		c.imm_byte = imm;
		return c;
	endfunction

	function automatic res_beat_t res_of(logic [7:0] al, logic [7:0] ah, logic [4:0] f,
			logic derr);
		res_beat_t r;
		r.al_out = al;
		r.ah_out = ah;
		{r.af_out, r.cf_out, r.sf_out, r.zf_out, r.pf_out} = f;
		r.divide_error = derr;
		return r;
	endfunction

	// what one 8086 adjust instruction leaves in al, ah and the flags
	function automatic res_beat_t adjust_regs(cmd_beat_t c);
		res_beat_t   r;
		logic        digit_fix;
		logic        byte_fix;
		logic [15:0] prod;
		r = res_of(c.al_in, c.ah_in, {c.af_in, c.cf_in, c.sf_in, c.zf_in, c.pf_in}, 1'b0);
		// both decisions look at the old al and flags
		digit_fix = (c.al_in[3:0] > DIGIT_MAX) || c.af_in;
		byte_fix  = (c.al_in > BYTE_MAX) || c.cf_in;
		case (c.mode)
			MODE_AAA, MODE_AAS: begin
				if (digit_fix) begin
					if (c.mode == MODE_AAA) begin
						r.al_out = c.al_in + ADJ_LOW;
						r.ah_out = c.ah_in + 8'd1;
					end else begin
						r.al_out = c.al_in - ADJ_LOW;
						r.ah_out = c.ah_in - 8'd1;
					end
				end
				r.af_out = digit_fix;
				r.cf_out = digit_fix;
				// high nibble cleared on both branches
				r.al_out = r.al_out & LOW_NIBBLE;
			end
			MODE_DAA, MODE_DAS: begin
				if (digit_fix) begin
					r.al_out = (c.mode == MODE_DAA) ? r.al_out + ADJ_LOW : r.al_out - ADJ_LOW;
				end
				if (byte_fix) begin
					r.al_out = (c.mode == MODE_DAA) ? r.al_out + ADJ_HIGH : r.al_out - ADJ_HIGH;
				end
				r.af_out = digit_fix;
				r.cf_out = byte_fix;
			end
			MODE_AAM: begin
				if (c.imm_byte == 8'd0) begin
					r.divide_error = 1'b1;
				end else begin
					r.ah_out = c.al_in / c.imm_byte;
					r.al_out = c.al_in % c.imm_byte;
					r.sf_out = r.al_out[7];
					r.zf_out = (r.al_out == 8'd0);
					r.pf_out = ~^r.al_out;
				end
			end
			MODE_AAD: begin
				prod     = c.ah_in * c.imm_byte;
				r.al_out = c.al_in + prod[7:0];
				r.ah_out = 8'd0;
				r.sf_out = r.al_out[7];
				r.zf_out = (r.al_out == 8'd0);
				r.pf_out = ~^r.al_out;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic note_fault(input string msg);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT) begin
			$display("%0t ns: %s", $realtime, msg);
		end
	endtask

	// mostly back to back, sometimes a short gap, rarely a long hole
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			return 0;
		end
		if (roll < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 30);
	endfunction

	// present one command beat after an optional idle stretch; start stays high across
	// back-to-back beats so it never gets two assignments in one step
	task automatic issue_beat(input cmd_beat_t c, input res_beat_t want, input int unsigned gap);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		expected_adjusts.push_back(want);
	endtask

	task automatic drain_pipe();
		start <= 1'b0;
		while (expected_adjusts.size() != 0) @(posedge clk);
	endtask

	// result checker: done and result are sampled before the edge updates them
	always @(posedge clk) begin
		res_beat_t want;
		if (arst_n && done) begin
			if (expected_adjusts.size() == 0) begin
				note_fault($sformatf("result beat with nothing pending: %p", result));
			end else begin
				want = expected_adjusts.pop_front();
				if (result.al_out !== want.al_out || result.ah_out !== want.ah_out ||
						result.af_out !== want.af_out || result.cf_out !== want.cf_out ||
						result.sf_out !== want.sf_out || result.zf_out !== want.zf_out ||
						result.pf_out !== want.pf_out ||
						result.divide_error !== want.divide_error) begin
					note_fault($sformatf({"mismatch (exp/got) al %h/%h ah %h/%h af %b/%b ",
						"cf %b/%b sf %b/%b zf %b/%b pf %b/%b derr %b/%b"},
						want.al_out, result.al_out, want.ah_out, result.ah_out,
						want.af_out, result.af_out, want.cf_out, result.cf_out,
						want.sf_out, result.sf_out, want.zf_out, result.zf_out,
						want.pf_out, result.pf_out, want.divide_error, result.divide_error));
				end
			end
		end
	end

	// stimulus
	initial begin
		directed_row_t row;
		cmd_beat_t     c;
		int unsigned   burst_left;
		burst_left = 0;

		// directed table: extremes, every mode, the no-op codes and the zero divisor
		// no digit fix: al kept, af and cf cleared, other flags pass
		directed_rows.push_back('{cmd_of(MODE_AAA, 8'h00, 8'h12, 5'b00101, 8'h00), 1'b1,
			res_of(8'h00, 8'h12, 5'b00101, 1'b0)});
		// low nibble above nine, ah wraps
		directed_rows.push_back('{cmd_of(MODE_AAA, 8'h0A, 8'hFF, 5'b00000, 8'hFF), 1'b0, '0});
		// af forces the fix
		directed_rows.push_back('{cmd_of(MODE_AAA, 8'h35, 8'h00, 5'b10000, 8'h00), 1'b0, '0});
		directed_rows.push_back('{cmd_of(MODE_AAA, 8'hFF, 8'h80, 5'b11111, 8'h00), 1'b0, '0});
		// subtract through zero, al masked afterwards
		directed_rows.push_back('{cmd_of(MODE_AAS, 8'h00, 8'h00, 5'b10000, 8'h00), 1'b0, '0});
		directed_rows.push_back('{cmd_of(MODE_AAS, 8'h0B, 8'h05, 5'b01010, 8'h00), 1'b0, '0});
		directed_rows.push_back('{cmd_of(MODE_AAS, 8'hF9, 8'h77, 5'b01111, 8'h55), 1'b0, '0});
		// largest packed value that needs no fix
		directed_rows.push_back('{cmd_of(MODE_DAA, 8'h99, 8'h3C, 5'b00000, 8'h00), 1'b1,
			res_of(8'h99, 8'h3C, 5'b00000, 1'b0)});
		directed_rows.push_back('{cmd_of(MODE_DAA, 8'h9A, 8'h00, 5'b00000, 8'h00), 1'b0, '0});
		directed_rows.push_back('{cmd_of(MODE_DAA, 8'hFF, 8'hFF, 5'b11111, 8'hFF), 1'b0, '0});
		// carry alone forces the high stage
		directed_rows.push_back('{cmd_of(MODE_DAA, 8'h00, 8'h00, 5'b01000, 8'h00), 1'b0, '0});
		directed_rows.push_back('{cmd_of(MODE_DAS, 8'h00, 8'h00, 5'b11000, 8'h00), 1'b0, '0});
		directed_rows.push_back('{cmd_of(MODE_DAS, 8'hA0, 8'h11, 5'b00111, 8'h00), 1'b0, '0});
		directed_rows.push_back('{cmd_of(MODE_DAS, 8'h0F, 8'h00, 5'b00000, 8'h00), 1'b0, '0});
		// zero divisor: inputs returned, divide_error raised
		directed_rows.push_back('{cmd_of(MODE_AAM, 8'h37, 8'hA5, 5'b10101, 8'h00), 1'b1,
			res_of(8'h37, 8'hA5, 5'b10101, 1'b1)});
		directed_rows.push_back('{cmd_of(MODE_AAM, 8'hFF, 8'h00, 5'b11010, 8'h0A), 1'b0, '0});
		directed_rows.push_back('{cmd_of(MODE_AAM, 8'h80, 8'h12, 5'b00000, 8'h01), 1'b0, '0});
		directed_rows.push_back('{cmd_of(MODE_AAM, 8'hFF, 8'hFF, 5'b11111, 8'hFF), 1'b0, '0});
		directed_rows.push_back('{cmd_of(MODE_AAM, 8'h00, 8'h33, 5'b00000, 8'hFF), 1'b0, '0});
		// full-scale fold, product wraps
		directed_rows.push_back('{cmd_of(MODE_AAD, 8'hFF, 8'hFF, 5'b11111, 8'hFF), 1'b0, '0});
		directed_rows.push_back('{cmd_of(MODE_AAD, 8'h05, 8'h07, 5'b00000, 8'h0A), 1'b0, '0});
		// all zero: ah cleared, zero and parity flags set
		directed_rows.push_back('{cmd_of(MODE_AAD, 8'h00, 8'h00, 5'b11000, 8'h00), 1'b1,
			res_of(8'h00, 8'h00, 5'b11011, 1'b0)});
		// unused codes pass everything through
		directed_rows.push_back('{cmd_of(MODE_SPARE_6, 8'hFF, 8'hFF, 5'b11111, 8'hFF), 1'b1,
			res_of(8'hFF, 8'hFF, 5'b11111, 1'b0)});
		directed_rows.push_back('{cmd_of(MODE_SPARE_7, 8'h00, 8'h00, 5'b00000, 8'h00), 1'b1,
			res_of(8'h00, 8'h00, 5'b00000, 1'b0)});

		// reset once
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			issue_beat(row.c, row.typed ? row.want : adjust_regs(row.c), pick_gap());
		end
		// hold off until the table has fully come back
		drain_pipe();

		for (int unsigned n = 0; n < RANDOM_BEATS; n++) begin
			c = cmd_beat_t'($urandom);
			// spare codes now and then, the six instructions otherwise
			if ($urandom_range(0, 15) == 0) begin
				c.mode = $urandom_range(0, 1) ? MODE_SPARE_6 : MODE_SPARE_7;
			end else begin
				c.mode = 3'($urandom_range(0, 5));
			end
			if (c.mode == MODE_AAM && $urandom_range(0, 9) == 0) begin
				c.imm_byte = 8'h00;
			end
			// stretches of back-to-back beats between idle patterns
			if (burst_left == 0 && $urandom_range(0, 19) == 0) begin
				burst_left = $urandom_range(20, 60);
			end
			if (burst_left != 0) begin
				burst_left--;
				issue_beat(c, adjust_regs(c), 0);
			end else begin
				issue_beat(c, adjust_regs(c), pick_gap());
			end
			if (n % DRAIN_EVERY == DRAIN_EVERY - 1) begin
				drain_pipe();
			end
		end

		drain_pipe();
		// watch a little longer for stray result beats
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
`default_nettype wire

// ===== bcd_adjust_unit.f =====
hdl/bcdu_pkg.sv
hdl/bcdu_cell.sv
hdl/bcd_adjust_unit.sv
bench/tb_bcd_adjust_unit.sv
